// ----- design/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PTD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ptd_pkg.sv -----
// Shared types, codes and decode tables for the transaction deframer.
// No dependencies; used by every module of the block.
package ptd_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_PANEL   = 2'd0;
  localparam logic [1:0] CMD_CTRL    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Frame kind codes.
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;
  localparam logic [1:0] KIND_RESP = 2'd3;

  // Delimiters and signature bytes.
  localparam logic [7:0] LONG_DELIM  = 8'h68;
  localparam logic [7:0] END_DELIM   = 8'h16;
  localparam logic [7:0] SHORT_DELIM = 8'h10;
  localparam logic [7:0] POLL_CODE   = 8'h5C;
  localparam logic [7:0] ACK_BYTE    = 8'hE5;
  localparam logic [7:0] SIG_PROTO   = 8'h32;
  localparam logic [7:0] SIG_RESP_HD = 8'h08;
  localparam logic [7:0] SIG_REQ_JOB = 8'h01;
  localparam logic [7:0] SIG_RESP_AK = 8'h03;
  localparam logic [7:0] MIN_LONG_LE = 8'h03;

  // Function codes.
  localparam logic [7:0] FUNC_READ  = 8'h04;
  localparam logic [7:0] FUNC_WRITE = 8'h05;
  localparam logic [7:0] FUNC_FORCE = 8'h00;

  // Access kind codes.
  localparam logic [1:0] ACC_READ    = 2'd0;
  localparam logic [1:0] ACC_WRITE   = 2'd1;
  localparam logic [1:0] ACC_FORCE   = 2'd2;
  localparam logic [1:0] ACC_UNKNOWN = 2'd3;

  // Item type codes.
  localparam logic [7:0] TYPE_BIT      = 8'h01;
  localparam logic [7:0] TYPE_DWORD    = 8'h04;
  localparam logic [7:0] TYPE_COUNTER  = 8'h1E;
  localparam logic [7:0] TYPE_TIMER    = 8'h1F;
  localparam logic [7:0] TYPE_FAST_CNT = 8'h20;
  localparam logic [2:0] ITEM_COUNTER  = 3'd4;
  localparam logic [2:0] ITEM_TIMER    = 3'd5;
  localparam logic [2:0] ITEM_FAST_CNT = 3'd6;
  localparam logic [2:0] ITEM_UNKNOWN  = 3'd7;

  // Frame byte positions.
  localparam logic [8:0] POS_HUNT     = 9'd0;
  localparam logic [8:0] POS_LEN      = 9'd1;
  localparam logic [8:0] POS_LEN_REP  = 9'd2;
  localparam logic [8:0] POS_DELIM2   = 9'd3;
  localparam logic [8:0] POS_BODY     = 9'd4;
  localparam logic [8:0] POS_SHORT_CK = 9'd4;
  localparam logic [8:0] POS_SHORT_EN = 9'd5;
  localparam logic [8:0] POS_SIG_A    = 9'd6;
  localparam logic [8:0] POS_SIG_B    = 9'd7;
  localparam logic [8:0] POS_SIG_C    = 9'd8;
  localparam logic [8:0] POS_FUNC     = 9'd17;
  localparam logic [8:0] POS_TYPE     = 9'd22;
  localparam logic [8:0] POS_AREA     = 9'd27;
  localparam logic [8:0] POS_ADDR_HI  = 9'd28;
  localparam logic [8:0] POS_ADDR_MID = 9'd29;
  localparam logic [8:0] POS_ADDR_LO  = 9'd30;
  localparam logic [8:0] LONG_OVERHD  = 9'd5;
  localparam logic [8:0] LONG_EXTRA   = 9'd6;
  localparam logic [8:0] ACK_LEN      = 9'd1;
  localparam logic [8:0] POLL_LEN     = 9'd6;

  // Known memory area codes.
  localparam int AREA_COUNT = 11;
  localparam logic [7:0] AREA_TABLE [AREA_COUNT] = '{
    8'h04, 8'h05, 8'h06, 8'h07, 8'h1E, 8'h1F, 8'h20, 8'h81, 8'h82, 8'h83, 8'h84
  };

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_ACK  = 2'd1,
    PH_WAIT_POLL = 2'd2,
    PH_WAIT_RESP = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_done;
    logic [1:0]  frame_kind;
    logic [8:0]  frame_length;
    logic        frame_error;
    logic [1:0]  phase;
    logic [1:0]  access_kind;
    logic [2:0]  item_type;
    logic [7:0]  area_code;
    logic        area_known;
    logic [20:0] byte_address;
  } out_item_t;

  // Captured request fields.
  typedef struct packed {
    logic [7:0]  func;
    logic [7:0]  itype;
    logic [7:0]  area;
    logic [23:0] addr;
  } cap_t;

  // Per-item frame status from the parser.
  typedef struct packed {
    logic       done;
    logic [1:0] kind;
    logic [8:0] length;
    logic       error;
    logic [1:0] phase;
  } frame_stat_t;

  // Decoded request fields.
  typedef struct packed {
    logic [1:0]  access_kind;
    logic [2:0]  item_type;
    logic [7:0]  area_code;
    logic        area_known;
    logic [20:0] byte_address;
  } dec_t;

endpackage

// ----- design/ppi_transaction_deframer.sv -----
// Path: an accepted item passes through the input register and then the result register.
// Throughput: one byte per cycle; the parser state updates as an item moves into the
// result register, and a stalled result holds the input once the input register is full.
// Reset: synchronous, active low; phase idle, frame hunting, captures cleared.
// Depends on ptd_pkg, ptd_frame_parser, ptd_field_decode and assert_macros.svh.
`include "assert_macros.svh"

module ppi_transaction_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ptd_pkg::out_item_t out_item
);

  logic                 in_vld_r;
  ptd_pkg::in_item_t    in_item_r;
  logic                 out_vld_r;
  ptd_pkg::out_item_t   out_item_r, out_item_nxt;
  logic                 advance;
  ptd_pkg::frame_stat_t stat;
  ptd_pkg::cap_t        cap_nxt;
  ptd_pkg::dec_t        dec;

  // An item moves on when the result register is empty or being drained.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  ptd_frame_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .stat    (stat),
    .cap_nxt (cap_nxt)
  );

  ptd_field_decode u_decode (
    .cap (cap_nxt),
    .dec (dec)
  );

  // Assemble the result item.
  always_comb begin
    out_item_nxt.frame_done   = stat.done;
    out_item_nxt.frame_kind   = stat.kind;
    out_item_nxt.frame_length = stat.length;
    out_item_nxt.frame_error  = stat.error;
    out_item_nxt.phase        = stat.phase;
    out_item_nxt.access_kind  = dec.access_kind;
    out_item_nxt.item_type    = dec.item_type;
    out_item_nxt.area_code    = dec.area_code;
    out_item_nxt.area_known   = dec.area_known;
    out_item_nxt.byte_address = dec.byte_address;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // A frame never completes and fails on the same byte.
  `PTD_ASSERT_IMPL(a_done_err_excl, out_vld_r, !(out_item_r.frame_done && out_item_r.frame_error), "frame_done and frame_error both set")
  // A length is reported exactly when a frame completes.
  `PTD_ASSERT_IMPL(a_len_iff_done, out_vld_r, (out_item_r.frame_done == (out_item_r.frame_length != 9'd0)), "frame_length does not match frame_done")
  // A held item with a stalled result blocks the input.
  `PTD_ASSERT_IMPL(a_stall_blocks, in_vld_r && out_vld_r && !out_ready, !in_ready, "input taken while both stages are full")
  // Every item that moves on shows up as a valid result.
  `PTD_ASSERT_NEXT(a_advance_out, advance, out_vld_r, "moved item not presented as result")

endmodule

// ----- design/ptd_frame_parser.sv -----
// Byte-level frame parser and transaction phase tracker.
// Depends on ptd_pkg.
module ptd_frame_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  ptd_pkg::in_item_t item,
  output ptd_pkg::frame_stat_t stat,
  output ptd_pkg::cap_t     cap_nxt
);

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_OK   = 2'd1,
    RES_FAIL = 2'd2
  } res_t;

  ptd_pkg::phase_t phase_r, phase_nxt;
  logic [8:0]      pos_r, pos_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic            sig_r, sig_nxt;
  ptd_pkg::cap_t   cap_r;

  logic [7:0]      b;
  logic            req;
  logic [8:0]      pos_inc;
  logic [8:0]      last;

  logic [8:0]      lg_pos;
  logic [7:0]      lg_len;
  logic [7:0]      lg_sum;
  logic            lg_sig;
  logic            lg_chk;
  ptd_pkg::cap_t   lg_cap;
  res_t            lg_res;

  logic [8:0]      sh_pos;
  logic [7:0]      sh_sum;
  logic            sh_sig;
  res_t            sh_res;

  assign b       = item.rx_byte;
  assign req     = (phase_r == ptd_pkg::PH_IDLE);
  assign pos_inc = pos_r + 9'd1;
  assign last    = ptd_pkg::LONG_OVERHD + {1'b0, len_r};

  // Long frame step: header hunt, signature checks, captures, FCS and end.
  always_comb begin
    lg_pos = pos_r;
    lg_len = len_r;
    lg_sum = sum_r;
    lg_sig = sig_r;
    lg_chk = sig_r;
    lg_cap = cap_r;
    lg_res = RES_NONE;
    if (pos_r == ptd_pkg::POS_HUNT) begin
      if (b == ptd_pkg::LONG_DELIM) begin
        lg_pos = ptd_pkg::POS_LEN;
        lg_sum = 8'd0;
        lg_sig = 1'b1;
        if (req) begin
          lg_cap = '0;
        end
      end
    end else if (pos_r == ptd_pkg::POS_LEN) begin
      lg_len = b;
      lg_pos = ptd_pkg::POS_LEN_REP;
    end else if (pos_r == ptd_pkg::POS_LEN_REP) begin
      lg_pos = (b == len_r) ? ptd_pkg::POS_DELIM2 : ptd_pkg::POS_HUNT;
    end else if (pos_r == ptd_pkg::POS_DELIM2) begin
      lg_pos = (b == ptd_pkg::LONG_DELIM) ? ptd_pkg::POS_BODY : ptd_pkg::POS_HUNT;
    end else begin
      if (req) begin
        if (pos_r == ptd_pkg::POS_SIG_B && b != ptd_pkg::SIG_PROTO) lg_chk = 1'b0;
        if (pos_r == ptd_pkg::POS_SIG_C && b != ptd_pkg::SIG_REQ_JOB) lg_chk = 1'b0;
        if (pos_r == ptd_pkg::POS_FUNC) lg_cap.func = b;
        if (pos_r == ptd_pkg::POS_TYPE) lg_cap.itype = b;
        if (pos_r == ptd_pkg::POS_AREA) lg_cap.area = b;
        if (pos_r == ptd_pkg::POS_ADDR_HI) lg_cap.addr = cap_r.addr | {b, 16'h0000};
        if (pos_r == ptd_pkg::POS_ADDR_MID) lg_cap.addr = cap_r.addr | {8'h00, b, 8'h00};
        if (pos_r == ptd_pkg::POS_ADDR_LO) lg_cap.addr = cap_r.addr | {16'h0000, b};
      end else begin
        if (pos_r == ptd_pkg::POS_SIG_A && b != ptd_pkg::SIG_RESP_HD) lg_chk = 1'b0;
        if (pos_r == ptd_pkg::POS_SIG_B && b != ptd_pkg::SIG_PROTO) lg_chk = 1'b0;
        if (pos_r == ptd_pkg::POS_SIG_C && b != ptd_pkg::SIG_RESP_AK) lg_chk = 1'b0;
      end
      if (pos_inc < last) begin
        lg_sum = sum_r + b;
        lg_pos = pos_inc;
        lg_sig = lg_chk;
      end else if (pos_inc == last) begin
        lg_sig = lg_chk && (b == sum_r);
        lg_pos = pos_inc;
      end else begin
        lg_sig = lg_chk && (b == ptd_pkg::END_DELIM) && (len_r >= ptd_pkg::MIN_LONG_LE);
        lg_pos = ptd_pkg::POS_HUNT;
        lg_res = lg_sig ? RES_OK : RES_FAIL;
      end
    end
  end

  // Short poll frame step.
  always_comb begin
    sh_pos = pos_r;
    sh_sum = sum_r;
    sh_sig = sig_r;
    sh_res = RES_NONE;
    if (pos_r == ptd_pkg::POS_HUNT) begin
      if (b == ptd_pkg::SHORT_DELIM) begin
        sh_pos = ptd_pkg::POS_LEN;
        sh_sum = 8'd0;
        sh_sig = 1'b1;
      end
    end else if (pos_r == ptd_pkg::POS_LEN || pos_r == ptd_pkg::POS_LEN_REP) begin
      sh_sum = sum_r + b;
      sh_pos = pos_inc;
    end else if (pos_r == ptd_pkg::POS_DELIM2) begin
      if (b == ptd_pkg::POLL_CODE) begin
        sh_sum = sum_r + b;
        sh_pos = ptd_pkg::POS_SHORT_CK;
      end else begin
        sh_pos = ptd_pkg::POS_HUNT;
      end
    end else if (pos_r == ptd_pkg::POS_SHORT_CK) begin
      sh_sig = sig_r && (b == sum_r);
      sh_pos = ptd_pkg::POS_SHORT_EN;
    end else begin
      sh_sig = sig_r && (b == ptd_pkg::END_DELIM);
      sh_pos = ptd_pkg::POS_HUNT;
      sh_res = sh_sig ? RES_OK : RES_FAIL;
    end
  end

  // Transaction phase tracking and selection of the frame step.
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    sig_nxt     = sig_r;
    cap_nxt     = cap_r;
    stat        = '0;
    if (item.command == ptd_pkg::CMD_TIMEOUT) begin
      phase_nxt = ptd_pkg::PH_IDLE;
      pos_nxt   = ptd_pkg::POS_HUNT;
      sum_nxt   = 8'd0;
      sig_nxt   = 1'b1;
    end else if (item.command != ptd_pkg::CMD_NONE) begin
      unique case (phase_r)
        ptd_pkg::PH_IDLE: begin
          if (item.command == ptd_pkg::CMD_PANEL) begin
            pos_nxt = lg_pos;
            len_nxt = lg_len;
            sum_nxt = lg_sum;
            sig_nxt = lg_sig;
            cap_nxt = lg_cap;
            stat.kind = ptd_pkg::KIND_REQ;
            if (lg_res == RES_OK) begin
              stat.done   = 1'b1;
              stat.length = {1'b0, lg_len} + ptd_pkg::LONG_EXTRA;
              phase_nxt   = ptd_pkg::PH_WAIT_ACK;
            end else if (lg_res == RES_FAIL) begin
              stat.error = 1'b1;
            end
          end
        end
        ptd_pkg::PH_WAIT_ACK: begin
          if (item.command == ptd_pkg::CMD_CTRL && b == ptd_pkg::ACK_BYTE) begin
            stat.done   = 1'b1;
            stat.kind   = ptd_pkg::KIND_ACK;
            stat.length = ptd_pkg::ACK_LEN;
            phase_nxt   = ptd_pkg::PH_WAIT_POLL;
            pos_nxt     = ptd_pkg::POS_HUNT;
          end
        end
        ptd_pkg::PH_WAIT_POLL: begin
          if (item.command == ptd_pkg::CMD_PANEL) begin
            pos_nxt = sh_pos;
            sum_nxt = sh_sum;
            sig_nxt = sh_sig;
            if (sh_res != RES_NONE) stat.kind = ptd_pkg::KIND_POLL;
            if (sh_res == RES_OK) begin
              stat.done   = 1'b1;
              stat.length = ptd_pkg::POLL_LEN;
              phase_nxt   = ptd_pkg::PH_WAIT_RESP;
            end else if (sh_res == RES_FAIL) begin
              stat.error = 1'b1;
            end
          end
        end
        ptd_pkg::PH_WAIT_RESP: begin
          if (item.command == ptd_pkg::CMD_CTRL) begin
            pos_nxt = lg_pos;
            len_nxt = lg_len;
            sum_nxt = lg_sum;
            sig_nxt = lg_sig;
            if (lg_res != RES_NONE) stat.kind = ptd_pkg::KIND_RESP;
            if (lg_res == RES_OK) begin
              stat.done   = 1'b1;
              stat.length = {1'b0, lg_len} + ptd_pkg::LONG_EXTRA;
              phase_nxt   = ptd_pkg::PH_IDLE;
            end else if (lg_res == RES_FAIL) begin
              stat.error = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = ptd_pkg::PH_IDLE;
        end
      endcase
    end
    stat.phase = phase_nxt;
  end

  // Parser state advances once per item taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ptd_pkg::PH_IDLE;
      pos_r   <= ptd_pkg::POS_HUNT;
      len_r   <= 8'd0;
      sum_r   <= 8'd0;
      sig_r   <= 1'b1;
      cap_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      sig_r   <= sig_nxt;
      cap_r   <= cap_nxt;
    end
  end

endmodule

// ----- design/ptd_field_decode.sv -----
// Decoder from captured request bytes to access kind, item type and area.
// Depends on ptd_pkg.
module ptd_field_decode (
  input  ptd_pkg::cap_t cap,
  output ptd_pkg::dec_t dec
);

  logic [1:0] acc_kind;
  logic [2:0] itm_type;
  logic       hit;

  // Access kind from the function code.
  always_comb begin
    if (cap.func == ptd_pkg::FUNC_READ) begin
      acc_kind = ptd_pkg::ACC_READ;
    end else if (cap.func == ptd_pkg::FUNC_WRITE) begin
      acc_kind = ptd_pkg::ACC_WRITE;
    end else if (cap.func == ptd_pkg::FUNC_FORCE) begin
      acc_kind = ptd_pkg::ACC_FORCE;
    end else begin
      acc_kind = ptd_pkg::ACC_UNKNOWN;
    end
  end

  // Item type: bit through dword map down by one; counters and timers are named.
  always_comb begin
    if (cap.itype >= ptd_pkg::TYPE_BIT && cap.itype <= ptd_pkg::TYPE_DWORD) begin
      itm_type = 3'(cap.itype - ptd_pkg::TYPE_BIT);
    end else if (cap.itype == ptd_pkg::TYPE_COUNTER) begin
      itm_type = ptd_pkg::ITEM_COUNTER;
    end else if (cap.itype == ptd_pkg::TYPE_TIMER) begin
      itm_type = ptd_pkg::ITEM_TIMER;
    end else if (cap.itype == ptd_pkg::TYPE_FAST_CNT) begin
      itm_type = ptd_pkg::ITEM_FAST_CNT;
    end else begin
      itm_type = ptd_pkg::ITEM_UNKNOWN;
    end
  end

  // Area lookup: parallel compares against the known-area table.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < ptd_pkg::AREA_COUNT; i++) begin
      if (ptd_pkg::AREA_TABLE[i] == cap.area) hit = 1'b1;
    end
  end

  // Pack the decoded fields; the byte address drops the three bit-select bits.
  assign dec = {acc_kind, itm_type, cap.area, hit, cap.addr[23:3]};

endmodule

// ----- test/tb_ppi_transaction_deframer.sv -----
// Self-checking testbench for the transaction deframer: directed corner cases, then random
// exchanges with flawed frames, stray bytes, timeouts and backpressure on both channels.
// Depends on ptd_pkg and the ppi_transaction_deframer RTL.
module tb_ppi_transaction_deframer;
  import ptd_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int TAIL_ITEMS   = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  // Outcome of one byte fed to a frame parser.
  typedef enum int {FR_BUSY, FR_DONE, FR_BAD} frame_step_t;

  // Ways a generated frame can be broken.
  typedef enum int {
    FLAW_NONE, FLAW_FCS, FLAW_END, FLAW_SIG, FLAW_LEN_REP, FLAW_DELIM
  } flaw_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  ppi_transaction_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // Byte stream waiting to be sent and results still owed by the block.
  in_item_t  pending_bytes[$];
  out_item_t due_results[$];
  int        n_counted = 0;
  int        bytes_sent = 0;
  int        fail_cnt = 0;
  int        stuck_cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  logic      in_took = 1'b0;
  int        done_by_kind [4] = '{default: 0};
  int        bad_frames = 0;

  // Deframer state as the predictor sees it.
  phase_t     ph = PH_IDLE;
  logic [8:0] pos = POS_HUNT;
  logic [7:0] le_seen = '0;
  logic [7:0] fcs_acc = '0;
  logic       sig_good = 1'b1;
  cap_t       cap = '0;

  // One byte of a long frame: request when is_req, response otherwise.
  function automatic frame_step_t long_frame_byte(input logic [7:0] b, input bit is_req);
    int p;
    int last;
    p = int'(pos);
    if (p == POS_HUNT) begin
      if (b == LONG_DELIM) begin
        pos = POS_LEN;
        fcs_acc = '0;
        sig_good = 1'b1;
        if (is_req) cap = '0;
      end
      return FR_BUSY;
    end
    if (p == POS_LEN) begin
      le_seen = b;
      pos = POS_LEN_REP;
      return FR_BUSY;
    end
    if (p == POS_LEN_REP) begin
      pos = (b == le_seen) ? POS_DELIM2 : POS_HUNT;
      return FR_BUSY;
    end
    if (p == POS_DELIM2) begin
      pos = (b == LONG_DELIM) ? POS_BODY : POS_HUNT;
      return FR_BUSY;
    end

    // Signature checks and captures look at the position, wherever the frame ends.
    if (is_req) begin
      if (p == POS_SIG_B && b != SIG_PROTO) sig_good = 1'b0;
      if (p == POS_SIG_C && b != SIG_REQ_JOB) sig_good = 1'b0;
      if (p == POS_FUNC) cap.func = b;
      if (p == POS_TYPE) cap.itype = b;
      if (p == POS_AREA) cap.area = b;
      if (p == POS_ADDR_HI) cap.addr[23:16] = cap.addr[23:16] | b;
      if (p == POS_ADDR_MID) cap.addr[15:8] = cap.addr[15:8] | b;
      if (p == POS_ADDR_LO) cap.addr[7:0] = cap.addr[7:0] | b;
    end else begin
      if (p == POS_SIG_A && b != SIG_RESP_HD) sig_good = 1'b0;
      if (p == POS_SIG_B && b != SIG_PROTO) sig_good = 1'b0;
      if (p == POS_SIG_C && b != SIG_RESP_AK) sig_good = 1'b0;
    end

    last = int'(LONG_OVERHD) + int'(le_seen);
    if (p + 1 < last) begin
      fcs_acc = fcs_acc + b;
      pos = 9'(p + 1);
      return FR_BUSY;
    end
    if (p + 1 == last) begin
      if (b != fcs_acc) sig_good = 1'b0;
      pos = 9'(p + 1);
      return FR_BUSY;
    end
    if (b != END_DELIM || le_seen < MIN_LONG_LE) sig_good = 1'b0;
    pos = POS_HUNT;
    return sig_good ? FR_DONE : FR_BAD;
  endfunction

  // One byte of a short poll frame.
  function automatic frame_step_t short_frame_byte(input logic [7:0] b);
    if (pos == POS_HUNT) begin
      if (b == SHORT_DELIM) begin
        pos = POS_LEN;
        fcs_acc = '0;
        sig_good = 1'b1;
      end
      return FR_BUSY;
    end
    if (pos == POS_LEN || pos == POS_LEN_REP) begin
      fcs_acc = fcs_acc + b;
      pos = pos + 9'd1;
      return FR_BUSY;
    end
    if (pos == POS_DELIM2) begin
      if (b == POLL_CODE) begin
        fcs_acc = fcs_acc + b;
        pos = POS_SHORT_CK;
      end else begin
        pos = POS_HUNT;
      end
      return FR_BUSY;
    end
    if (pos == POS_SHORT_CK) begin
      if (b != fcs_acc) sig_good = 1'b0;
      pos = POS_SHORT_EN;
      return FR_BUSY;
    end
    if (b != END_DELIM) sig_good = 1'b0;
    pos = POS_HUNT;
    return sig_good ? FR_DONE : FR_BAD;
  endfunction

  // Advances the predicted deframer by one item and returns the result it owes.
  function automatic out_item_t parse_byte(input in_item_t it);
    out_item_t   r;
    frame_step_t st;
    r = '0;
    st = FR_BUSY;
    case (it.command)
      CMD_TIMEOUT: begin
        ph = PH_IDLE;
        pos = POS_HUNT;
        fcs_acc = '0;
        sig_good = 1'b1;
      end
      CMD_NONE: begin
      end
      default: begin
        case (ph)
          PH_IDLE: begin
            if (it.command == CMD_PANEL) begin
              st = long_frame_byte(it.rx_byte, 1'b1);
              r.frame_kind = KIND_REQ;
              if (st == FR_DONE) begin
                r.frame_length = LONG_EXTRA + le_seen;
                ph = PH_WAIT_ACK;
              end
            end
          end
          PH_WAIT_ACK: begin
            if (it.command == CMD_CTRL && it.rx_byte == ACK_BYTE) begin
              st = FR_DONE;
              r.frame_kind = KIND_ACK;
              r.frame_length = ACK_LEN;
              ph = PH_WAIT_POLL;
              pos = POS_HUNT;
            end
          end
          PH_WAIT_POLL: begin
            if (it.command == CMD_PANEL) begin
              st = short_frame_byte(it.rx_byte);
              if (st != FR_BUSY) r.frame_kind = KIND_POLL;
              if (st == FR_DONE) begin
                r.frame_length = POLL_LEN;
                ph = PH_WAIT_RESP;
              end
            end
          end
          default: begin
            if (it.command == CMD_CTRL) begin
              st = long_frame_byte(it.rx_byte, 1'b0);
              if (st != FR_BUSY) r.frame_kind = KIND_RESP;
              if (st == FR_DONE) begin
                r.frame_length = LONG_EXTRA + le_seen;
                ph = PH_IDLE;
              end
            end
          end
        endcase
      end
    endcase
    r.frame_done = (st == FR_DONE);
    r.frame_error = (st == FR_BAD);
    r.phase = ph;

    // Decoded request fields always reflect the captured bytes.
    case (cap.func)
      FUNC_READ:  r.access_kind = ACC_READ;
      FUNC_WRITE: r.access_kind = ACC_WRITE;
      FUNC_FORCE: r.access_kind = ACC_FORCE;
      default:    r.access_kind = ACC_UNKNOWN;
    endcase
    if (cap.itype >= TYPE_BIT && cap.itype <= TYPE_DWORD) begin
      r.item_type = 3'(cap.itype - TYPE_BIT);
    end else begin
      case (cap.itype)
        TYPE_COUNTER:  r.item_type = ITEM_COUNTER;
        TYPE_TIMER:    r.item_type = ITEM_TIMER;
        TYPE_FAST_CNT: r.item_type = ITEM_FAST_CNT;
        default:       r.item_type = ITEM_UNKNOWN;
      endcase
    end
    r.area_code = cap.area;
    for (int i = 0; i < AREA_COUNT; i++) begin
      if (AREA_TABLE[i] == cap.area) r.area_known = 1'b1;
    end
    r.byte_address = cap.addr[23:3];

    if (r.frame_done) done_by_kind[r.frame_kind]++;
    if (r.frame_error) bad_frames++;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Stimulus builders.
  task automatic push_byte(input logic [1:0] cmd, input logic [7:0] b);
    in_item_t it;
    it.command = cmd;
    it.rx_byte = b;
    pending_bytes.push_back(it);
    if (cmd != CMD_NONE) n_counted++;
  endtask

  // Sends a frame byte, sometimes preceded by a byte the current phase must ignore.
  task automatic push_own(input logic [1:0] cmd, input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) begin
      if ($urandom_range(0, 2) == 0) push_byte(CMD_NONE, 8'($urandom));
      else push_byte((cmd == CMD_PANEL) ? CMD_CTRL : CMD_PANEL, 8'($urandom));
    end
    push_byte(cmd, b);
  endtask

  function automatic flaw_t pick_flaw();
    if ($urandom_range(0, 99) < 82) return FLAW_NONE;
    return flaw_t'($urandom_range(1, 5));
  endfunction

  // Long frame: a request with random captured fields, or a response.
  task automatic send_long(input bit is_req, input flaw_t flaw);
    logic [7:0] fr [0:260];
    int         fix_pos [8];
    logic [7:0] fix_val [8];
    int         n_fix;
    int         le;
    int         n_out;
    int         r;
    int         k;
    logic [7:0] sum;
    logic [1:0] own;
    logic [23:0] addr;
    own = is_req ? CMD_PANEL : CMD_CTRL;
    r = $urandom_range(0, 99);
    if (r >= 98) le = $urandom_range(200, 255);
    else if (flaw != FLAW_NONE && r < 20) le = $urandom_range(0, 3);
    else if (!is_req) le = $urandom_range(4, 16);
    else if (r < 45) le = $urandom_range(27, 36);
    else if (r < 70) le = $urandom_range(13, 26);
    else le = $urandom_range(4, 12);

    if (is_req) begin
      case ($urandom_range(0, 3))
        0:       fix_val[2] = FUNC_READ;
        1:       fix_val[2] = FUNC_WRITE;
        2:       fix_val[2] = FUNC_FORCE;
        default: fix_val[2] = 8'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       fix_val[3] = TYPE_BIT + 8'($urandom_range(0, 3));
        1:       fix_val[3] = TYPE_COUNTER;
        2:       fix_val[3] = TYPE_TIMER;
        3:       fix_val[3] = TYPE_FAST_CNT;
        default: fix_val[3] = 8'($urandom);
      endcase
      fix_val[4] = ($urandom_range(0, 9) < 6) ? AREA_TABLE[$urandom_range(0, AREA_COUNT - 1)]
                                               : 8'($urandom);
      case ($urandom_range(0, 5))
        0:       addr = '0;
        1:       addr = '1;
        default: addr = 24'($urandom);
      endcase
      fix_pos = '{POS_SIG_B, POS_SIG_C, POS_FUNC, POS_TYPE, POS_AREA,
                  POS_ADDR_HI, POS_ADDR_MID, POS_ADDR_LO};
      fix_val[0] = SIG_PROTO;
      fix_val[1] = SIG_REQ_JOB;
      fix_val[5] = addr[23:16];
      fix_val[6] = addr[15:8];
      fix_val[7] = addr[7:0];
      n_fix = 8;
    end else begin
      fix_pos[0] = POS_SIG_A;
      fix_pos[1] = POS_SIG_B;
      fix_pos[2] = POS_SIG_C;
      fix_val[0] = SIG_RESP_HD;
      fix_val[1] = SIG_PROTO;
      fix_val[2] = SIG_RESP_AK;
      n_fix = 3;
    end

    // Header, random body with the fixed bytes laid in, checksum and end byte.
    fr[0] = LONG_DELIM;
    fr[1] = 8'(le);
    fr[2] = 8'(le);
    fr[3] = LONG_DELIM;
    for (int i = 4; i < 4 + le; i++) fr[i] = 8'($urandom);
    for (int i = 0; i < n_fix; i++) begin
      if (fix_pos[i] < 4 + le) fr[fix_pos[i]] = fix_val[i];
    end
    sum = '0;
    for (int i = 4; i < 4 + le; i++) sum = sum + fr[i];
    // With a four-byte body the last signature byte is the checksum itself.
    if (le == 4) begin
      k = is_req ? 1 : 2;
      fr[4] = fr[4] + fix_val[k] - sum;
      sum = fix_val[k];
    end
    fr[4 + le] = sum;
    fr[5 + le] = END_DELIM;
    n_out = le + 6;

    case (flaw)
      FLAW_FCS: fr[4 + le] ^= 8'($urandom_range(1, 255));
      FLAW_END: fr[5 + le] ^= 8'($urandom_range(1, 255));
      FLAW_SIG: begin
        k = fix_pos[$urandom_range(0, is_req ? 1 : 2)];
        if (k > 5 + le) k = 4 + le;
        fr[k] ^= 8'($urandom_range(1, 255));
      end
      FLAW_LEN_REP: begin
        fr[2] ^= 8'($urandom_range(1, 255));
        n_out = 3;
      end
      FLAW_DELIM: begin
        fr[3] ^= 8'($urandom_range(1, 255));
        n_out = 4;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < n_out; i++) push_own(own, fr[i]);
  endtask

  // Acceptance, prediction, result checking and the watchdog.
  always @(posedge clk) begin : monitor
    if (!rst_n) begin
      in_took <= 1'b0;
      stuck_cycles = 0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) due_results.push_back(parse_byte(in_item));
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result item arrived with no expected result pending");
          fail_cnt++;
        end else begin
          out_item_t want;
          want = due_results.pop_front();
          check_field("frame_done", 32'(want.frame_done), 32'(out_item.frame_done));
          check_field("frame_kind", 32'(want.frame_kind), 32'(out_item.frame_kind));
          check_field("frame_length", 32'(want.frame_length), 32'(out_item.frame_length));
          check_field("frame_error", 32'(want.frame_error), 32'(out_item.frame_error));
          check_field("phase", 32'(want.phase), 32'(out_item.phase));
          check_field("access_kind", 32'(want.access_kind), 32'(out_item.access_kind));
          check_field("item_type", 32'(want.item_type), 32'(out_item.item_type));
          check_field("area_code", 32'(want.area_code), 32'(out_item.area_code));
          check_field("area_known", 32'(want.area_known), 32'(out_item.area_known));
          check_field("byte_address", 32'(want.byte_address), 32'(out_item.byte_address));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, due_results.size());
          $display("tb_ppi_transaction_deframer: FAIL");
          $finish;
        end
      end
    end
  end

  // Drives input items and result backpressure on the falling edge.
  always @(negedge clk) begin : driver
    bit may_idle;
    may_idle = (pending_bytes.size() >= TAIL_ITEMS) && (((bytes_sent >> 8) % 4) != 3);
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (may_idle && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else begin
          in_item <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          bytes_sent++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (may_idle && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Builds the whole byte stream, runs reset and waits for the block to drain.
  initial begin : stimulus
    flaw_t      flaw;
    int         abort_step;
    logic [1:0] own;
    logic [7:0] b;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] pf [6];
    int         n_out;

    // Directed: ignored commands, a timeout, a too-short request and broken headers.
    push_byte(CMD_NONE, 8'hFF);
    push_byte(CMD_CTRL, LONG_DELIM);
    push_byte(CMD_TIMEOUT, 8'h00);
    push_byte(CMD_PANEL, LONG_DELIM);
    push_byte(CMD_PANEL, 8'h00);
    push_byte(CMD_PANEL, 8'h00);
    push_byte(CMD_PANEL, LONG_DELIM);
    push_byte(CMD_PANEL, 8'h00);
    push_byte(CMD_PANEL, END_DELIM);
    push_byte(CMD_PANEL, LONG_DELIM);
    push_byte(CMD_PANEL, 8'h03);
    push_byte(CMD_PANEL, 8'h04);
    push_byte(CMD_PANEL, LONG_DELIM);
    push_byte(CMD_PANEL, 8'h03);
    push_byte(CMD_PANEL, 8'h03);
    push_byte(CMD_PANEL, 8'h00);
    push_byte(CMD_CTRL, ACK_BYTE);
    push_byte(CMD_PANEL, 8'hFF);

    // Random: mostly full exchanges with occasional flaws, aborts and noise bursts.
    while (n_counted < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) push_byte(CMD_TIMEOUT, 8'($urandom));
      if ($urandom_range(0, 9) < 8) begin
        abort_step = $urandom_range(0, 15);
        for (int step = 0; step < 4; step++) begin
          if (step == abort_step) begin
            // Partial frame cut off by a timeout.
            own = (step % 2 == 0) ? CMD_PANEL : CMD_CTRL;
            push_byte(own, (step == 2) ? SHORT_DELIM : LONG_DELIM);
            repeat ($urandom_range(0, 6)) push_byte(own, 8'($urandom));
            push_byte(CMD_TIMEOUT, 8'($urandom));
            break;
          end
          case (step)
            0: begin
              do begin
                flaw = pick_flaw();
                send_long(1'b1, flaw);
              end while (flaw != FLAW_NONE);
            end
            1: begin
              // Skipped bytes while waiting for the acknowledge.
              repeat ($urandom_range(0, 3)) begin
                b = 8'($urandom);
                if (b == ACK_BYTE) b = ~b;
                push_byte(($urandom_range(0, 1) != 0) ? CMD_CTRL : CMD_PANEL, b);
              end
              push_byte(CMD_CTRL, ACK_BYTE);
            end
            2: begin
              repeat ($urandom_range(0, 2)) begin
                b = 8'($urandom);
                if (b == SHORT_DELIM) b = ~b;
                push_byte(CMD_PANEL, b);
              end
              do begin
                flaw = pick_flaw();
                pa = 8'($urandom);
                pb = 8'($urandom);
                pf = '{SHORT_DELIM, pa, pb, POLL_CODE, 8'(pa + pb + POLL_CODE), END_DELIM};
                n_out = 6;
                case (flaw)
                  FLAW_NONE: begin
                  end
                  FLAW_END: pf[5] ^= 8'($urandom_range(1, 255));
                  FLAW_DELIM, FLAW_LEN_REP: begin
                    pf[3] ^= 8'($urandom_range(1, 255));
                    n_out = 4;
                  end
                  default: pf[4] ^= 8'($urandom_range(1, 255));
                endcase
                for (int i = 0; i < n_out; i++) push_own(CMD_PANEL, pf[i]);
              end while (flaw != FLAW_NONE);
            end
            default: begin
              do begin
                flaw = pick_flaw();
                send_long(1'b0, flaw);
              end while (flaw != FLAW_NONE);
            end
          endcase
        end
      end else begin
        // Noise rich in delimiter bytes, cleaned up by a timeout.
        repeat ($urandom_range(1, 20)) begin
          case ($urandom_range(0, 5))
            0:       b = LONG_DELIM;
            1:       b = SHORT_DELIM;
            2:       b = END_DELIM;
            3:       b = ACK_BYTE;
            default: b = 8'($urandom);
          endcase
          push_byte(2'($urandom_range(0, 3)), b);
        end
        push_byte(CMD_TIMEOUT, 8'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid || due_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; completed %0d requests, %0d acks, %0d polls, %0d responses,",
             bytes_sent, done_by_kind[KIND_REQ], done_by_kind[KIND_ACK],
             done_by_kind[KIND_POLL], done_by_kind[KIND_RESP]);
    $display("and saw %0d failed frames.", bad_frames);
    if (fail_cnt == 0) begin
      $display("tb_ppi_transaction_deframer: PASS");
    end else begin
      $display("tb_ppi_transaction_deframer: FAIL");
    end
    $finish;
  end

endmodule
